/* sv/rmr_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rmr_pkg: shared types and constants of the rangefinder reply receiver
// Frame layout, CRC-16 step, command item between the front and the back,
// and configuration register indexes.
// ---------------------------------------------------------------------------
package rmr_pkg;

    // frame layout: addr, func, count, dist hi/lo, conf hi/lo, crc lo, crc hi
    localparam logic [3:0] ADDR_IDX       = 4'd0;
    localparam logic [3:0] FUNC_IDX       = 4'd1;
    localparam logic [3:0] PAY_FIRST_IDX  = 4'd3;
    localparam logic [3:0] PAY_LAST_IDX   = 4'd6;
    localparam logic [3:0] CRC_LOW_IDX    = 4'd7;
    localparam logic [3:0] LAST_BYTE_IDX  = 4'd8;
    localparam logic [3:0] FRAME_DONE_IDX = 4'd9;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;

    // input item kinds (tuser bit 0)
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result item kinds (m_axis_tuser)
    localparam logic RES_READING = 1'b0;
    localparam logic RES_LINK    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR    = 2'd0;
    localparam logic [1:0] CFG_OUT_OF_RANGE  = 2'd1;
    localparam logic [1:0] CFG_OFFLINE_LIMIT = 2'd2;

    localparam logic [7:0]  SLAVE_ADDR_RST    = 8'd1;
    localparam logic [15:0] OUT_OF_RANGE_RST  = 16'd5000;
    localparam logic [7:0]  OFFLINE_LIMIT_RST = 8'd60;
    localparam logic [7:0]  OFFLINE_SAT       = 8'hFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int OUT_DATA_W = 40;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        addr_match;
        logic        crc_ok;
        logic        is_read;
        logic [15:0] distance;
        logic [15:0] confidence;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] distance_mm;
        logic [15:0] confidence;
        logic        crc_ok;
        logic        online;
    } res_t;

    // one byte of CRC-16, reflected polynomial, eight shifts unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* sv/rmr_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rmr_front: byte framing and CRC
// Tracks the byte index, runs the CRC over the first seven bytes, captures
// address match, function code and payload, and pushes one command item
// per completed frame or heartbeat tick.
// ---------------------------------------------------------------------------
module rmr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]    s_axis_tuser,   // [0] req_type, [1] frame_start
    input  wire logic [7:0]    slave_address,
    input  wire rmr_pkg::fifo_stat_t fifo_stat,
    output logic               push,
    output rmr_pkg::cmd_t      push_cmd
);
    import rmr_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        match_reg, match_next;
    logic [7:0]  func_reg, func_next;
    logic [31:0] payload_reg, payload_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        accept;
    logic        is_tick;
    logic        start;
    logic [3:0]  idx_cur;
    logic [15:0] crc_cur;
    logic        in_frame;

    assign s_axis_tready = !fifo_stat.full;
    assign accept        = s_axis_tvalid && !fifo_stat.full;
    assign is_tick       = (s_axis_tuser[0] == REQ_TICK);
    assign start         = s_axis_tuser[1];
    assign idx_cur       = start ? ADDR_IDX : idx_reg;
    assign crc_cur       = start ? CRC_INIT : crc_reg;
    assign in_frame      = (idx_cur < FRAME_DONE_IDX);

    always_comb
    begin
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        match_next   = match_reg;
        func_next    = func_reg;
        payload_next = payload_reg;
        crc_low_next = crc_low_reg;
        if (accept && !is_tick)
        begin
            idx_next = idx_cur;
            crc_next = crc_cur;
            if (in_frame)
            begin
                if (idx_cur < CRC_LOW_IDX)
                begin
                    crc_next = crc16_byte(crc_cur, s_axis_tdata);
                end
                if (idx_cur == ADDR_IDX)
                begin
                    match_next = (s_axis_tdata == slave_address);
                end
                if (idx_cur == FUNC_IDX)
                begin
                    func_next = s_axis_tdata;
                end
                if (idx_cur inside {[PAY_FIRST_IDX:PAY_LAST_IDX]})
                begin
                    payload_next = {payload_reg[23:0], s_axis_tdata};
                end
                if (idx_cur == CRC_LOW_IDX)
                begin
                    crc_low_next = s_axis_tdata;
                end
                idx_next = idx_cur + 4'd1;
            end
        end
    end

    // push on ticks and on the last byte of a frame
    assign push = accept && (is_tick || (in_frame && idx_cur == LAST_BYTE_IDX));

    always_comb
    begin
        push_cmd.kind       = is_tick ? CMD_TICK : CMD_FRAME;
        push_cmd.addr_match = match_reg;
        push_cmd.crc_ok     = ({s_axis_tdata, crc_low_reg} == crc_cur);
        push_cmd.is_read    = (func_reg == FUNC_READ);
        push_cmd.distance   = payload_reg[31:16];
        push_cmd.confidence = payload_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= ADDR_IDX;
            crc_reg     <= CRC_INIT;
            match_reg   <= 1'b0;
            func_reg    <= 8'h00;
            payload_reg <= 32'h0;
            crc_low_reg <= 8'h00;
        end
        else
        begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            match_reg   <= match_next;
            func_reg    <= func_next;
            payload_reg <= payload_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule
`default_nettype wire

/* sv/rmr_cmd_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rmr_cmd_fifo: command queue between front and back
// Small circular buffer of command items with full and empty status.
// ---------------------------------------------------------------------------
module rmr_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rmr_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output rmr_pkg::cmd_t       pop_cmd,
    output rmr_pkg::fifo_stat_t stat
);
    import rmr_pkg::*;

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

/* sv/rmr_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rmr_back: reading store, offline watchdog and result register
// Carries out frame and tick commands, keeps the stored reading and the
// link state, and holds each result in an output register.
// ---------------------------------------------------------------------------
module rmr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rmr_pkg::fifo_stat_t          fifo_stat,
    output logic                              pop,
    input  wire rmr_pkg::cmd_t                pop_cmd,
    input  wire logic [15:0]                  out_of_range_mm,
    input  wire logic [7:0]                   offline_limit,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [15:0] distance_mm, [31:16] confidence, [32] crc_ok, [33] online, zero pad
    output logic [rmr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser   // result_kind
);
    import rmr_pkg::*;

    logic [15:0] dist_reg, dist_next;
    logic [15:0] conf_reg, conf_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        online_reg, online_next;
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg, res_next;
    logic        load;
    logic [7:0]  cnt_inc;

    assign pop     = !fifo_stat.empty && (!out_valid_reg || m_axis_tready);
    assign cnt_inc = (cnt_reg != OFFLINE_SAT) ? cnt_reg + 8'd1 : cnt_reg;

    always_comb
    begin
        dist_next   = dist_reg;
        conf_next   = conf_reg;
        cnt_next    = cnt_reg;
        online_next = online_reg;
        res_next    = res_reg;
        load        = 1'b0;
        if (pop)
        begin
            if (pop_cmd.kind == CMD_TICK)
            begin
                if (cnt_inc > offline_limit)
                begin
                    cnt_next    = offline_limit;
                    online_next = 1'b0;
                end
                else
                begin
                    cnt_next    = cnt_inc;
                    online_next = 1'b1;
                end
                load                 = 1'b1;
                res_next.kind        = RES_LINK;
                res_next.distance_mm = 16'd0;
                res_next.confidence  = conf_reg;
                res_next.crc_ok      = 1'b0;
                res_next.online      = online_next;
            end
            else
            begin
                cnt_next = 8'd0;
                if (pop_cmd.addr_match)
                begin
                    load            = 1'b1;
                    res_next.kind   = RES_READING;
                    res_next.online = online_reg;
                    if (!pop_cmd.crc_ok)
                    begin
                        res_next.distance_mm = 16'd0;
                        res_next.confidence  = conf_reg;
                        res_next.crc_ok      = 1'b0;
                    end
                    else
                    begin
                        if (pop_cmd.is_read)
                        begin
                            dist_next = pop_cmd.distance;
                            conf_next = pop_cmd.confidence;
                        end
                        // zero confidence: report the out-of-range distance
                        res_next.distance_mm = (conf_next == 16'd0) ? out_of_range_mm
                                                                    : dist_next;
                        res_next.confidence  = conf_next;
                        res_next.crc_ok      = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg      <= 16'd0;
            conf_reg      <= 16'd0;
            cnt_reg       <= OFFLINE_SAT;
            online_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dist_reg      <= dist_next;
            conf_reg      <= conf_next;
            cnt_reg       <= cnt_next;
            online_reg    <= online_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {{(OUT_DATA_W-34){1'b0}}, res_reg.online, res_reg.crc_ok,
                            res_reg.confidence, res_reg.distance_mm};

endmodule
`default_nettype wire

/* sv/rangefinder_modbus_reply_receiver_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rangefinder_modbus_reply_receiver_unit: Modbus RTU rangefinder reply receiver
// Parses 9-byte replies, checks CRC-16, stores the reading and runs an
// offline watchdog on heartbeat ticks.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one item per received byte or heartbeat tick. tuser[0] selects
//   byte (0) or tick (1); tuser[1] marks the first byte of a frame.
//   m_axis: at most one result per item: a reading on the ninth byte of a
//   frame whose address matches, or a link status after every tick.
//   cfg: write channel, index 0 slave address, 1 out-of-range distance,
//   2 offline limit; other indexes are dropped. cfg_ready is always high.
//   Throughput is one item per cycle while the command queue is not full.
//   A result is registered: the front writes the command queue on the
//   accepting edge and the back loads its result register from the queue.
//   When m_axis stalls, the 4-entry command queue absorbs items and s_axis
//   drops tready only once it is full; nothing is lost.
//   Reset clears the frame index and CRC, the stored reading, the queue and
//   the result valid flag; the watchdog starts saturated, the link offline,
//   and the registers take their default values.
// ---------------------------------------------------------------------------
module rangefinder_modbus_reply_receiver_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]                 s_axis_tuser,   // [0] req_type, [1] frame_start
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [15:0] distance_mm, [31:16] confidence, [32] crc_ok, [33] online, zero pad
    output logic [rmr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,   // [0] result_kind
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [15:0]                cfg_data
);
    import rmr_pkg::*;

    logic [7:0]  slave_address_reg;
    logic [15:0] out_of_range_reg;
    logic [7:0]  offline_limit_reg;

    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    cmd_t       pop_cmd;
    fifo_stat_t fifo_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= SLAVE_ADDR_RST;
            out_of_range_reg  <= OUT_OF_RANGE_RST;
            offline_limit_reg <= OFFLINE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR:    slave_address_reg <= cfg_data[7:0];
                CFG_OUT_OF_RANGE:  out_of_range_reg  <= cfg_data;
                CFG_OFFLINE_LIMIT: offline_limit_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    rmr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .slave_address (slave_address_reg),
        .fifo_stat     (fifo_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    rmr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (fifo_stat)
    );

    rmr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_stat       (fifo_stat),
        .pop             (pop),
        .pop_cmd         (pop_cmd),
        .out_of_range_mm (out_of_range_reg),
        .offline_limit   (offline_limit_reg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser)
    );

endmodule
`default_nettype wire

/* sv/rmr_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rmr_checker: port checks for the reply receiver
// Watches the result channel for reset behaviour, stall hold and the
// field rules of link-status and failed-CRC results.
// ---------------------------------------------------------------------------
module rmr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [rmr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tuser
);
    import rmr_pkg::*;

    // no result straight after a reset edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // link status carries no distance and no CRC flag
    a_link_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RES_LINK |->
            m_axis_tdata[15:0] == 16'd0 && !m_axis_tdata[32])
        else $error("link status with distance or crc flag");

    // failed CRC reports zero distance
    a_crc_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RES_READING && !m_axis_tdata[32] |->
            m_axis_tdata[15:0] == 16'd0)
        else $error("failed reading with non-zero distance");

endmodule

bind rangefinder_modbus_reply_receiver_unit rmr_checker u_rmr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

/* tb/sv/tb_rangefinder_modbus_reply_receiver_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rangefinder_modbus_reply_receiver_unit: self-checking bench for the reply receiver
// Streams reply frames, line noise and heartbeat ticks into the receiver. A
// behavioural tracker of the frame parser and the offline watchdog predicts
// every result item, which is checked field by field as it leaves. Runs
// through several register settings and flow-control patterns.
// ---------------------------------------------------------------------------
module tb_rangefinder_modbus_reply_receiver_unit;
    import rmr_pkg::*;

    localparam logic [1:0] CFG_SPARE    = 2'd3;   // not decoded, write is dropped
    localparam int         DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       start;
    } link_item_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index     = '0;
    logic [15:0]           cfg_data      = '0;

    // byte stream waiting to go out, and readings/status due back
    link_item_t rx_items[$];
    res_t       due_reports[$];

    int   fault_count    = 0;
    int   items_issued   = 0;
    int   items_taken    = 0;
    int   send_idle_pct  = 0;
    int   sink_stall_pct = 0;
    logic s_fire         = 1'b0;

    // register values as the stimulus side believes them
    logic [7:0] st_addr;
    logic [7:0] st_limit;

    // tracker of the receiver: registers and parser state
    logic [7:0]  trk_addr;
    logic [15:0] trk_oor;
    logic [7:0]  trk_limit;
    logic [3:0]  trk_index;
    logic [15:0] trk_crc;
    logic        trk_addr_hit;
    logic [7:0]  trk_func;
    logic [31:0] trk_payload;
    logic [7:0]  trk_crc_low;
    logic [15:0] trk_dist;
    logic [15:0] trk_conf;
    logic [7:0]  trk_silence;
    logic        trk_online;

    rangefinder_modbus_reply_receiver_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    function automatic res_t report(input logic kind, input logic [15:0] dist_mm,
                                    input logic ok);
        res_t r;
        r.kind        = kind;
        r.distance_mm = dist_mm;
        r.confidence  = trk_conf;
        r.crc_ok      = ok;
        r.online      = trk_online;
        return r;
    endfunction

    task automatic reset_tracker();
        trk_addr     = SLAVE_ADDR_RST;
        trk_oor      = OUT_OF_RANGE_RST;
        trk_limit    = OFFLINE_LIMIT_RST;
        trk_index    = ADDR_IDX;
        trk_crc      = CRC_INIT;
        trk_addr_hit = 1'b0;
        trk_func     = '0;
        trk_payload  = '0;
        trk_crc_low  = '0;
        trk_dist     = '0;
        trk_conf     = '0;
        trk_silence  = OFFLINE_SAT;
        trk_online   = 1'b0;
    endtask

    // advance the parser and watchdog by one accepted item
    task automatic advance_parser(input link_item_t it);
        if (it.req == REQ_TICK)
        begin
            if (trk_silence != OFFLINE_SAT)
                trk_silence = trk_silence + 8'd1;
            if (trk_silence > trk_limit)
            begin
                trk_silence = trk_limit;
                trk_online  = 1'b0;
            end
            else
                trk_online = 1'b1;
            due_reports.push_back(report(RES_LINK, 16'h0000, 1'b0));
            return;
        end
        if (it.start)
        begin
            trk_index = ADDR_IDX;
            trk_crc   = CRC_INIT;
        end
        // past the ninth byte: hold until the next frame start
        if (trk_index >= FRAME_DONE_IDX)
            return;
        if (trk_index < CRC_LOW_IDX)
            trk_crc = crc16_step(trk_crc, it.data);
        if (trk_index == ADDR_IDX)
            trk_addr_hit = (it.data == trk_addr);
        else if (trk_index == FUNC_IDX)
            trk_func = it.data;
        else if (trk_index >= PAY_FIRST_IDX && trk_index <= PAY_LAST_IDX)
            trk_payload = {trk_payload[23:0], it.data};
        else if (trk_index == CRC_LOW_IDX)
            trk_crc_low = it.data;
        if (trk_index != LAST_BYTE_IDX)
        begin
            trk_index = trk_index + 4'd1;
            return;
        end
        trk_index   = FRAME_DONE_IDX;
        trk_silence = '0;
        if (!trk_addr_hit)
            return;
        if ({it.data, trk_crc_low} != trk_crc)
        begin
            due_reports.push_back(report(RES_READING, 16'h0000, 1'b0));
            return;
        end
        if (trk_func == FUNC_READ)
        begin
            trk_dist = trk_payload[31:16];
            trk_conf = trk_payload[15:0];
        end
        due_reports.push_back(report(RES_READING,
                                     (trk_conf == 16'h0000) ? trk_oor : trk_dist, 1'b1));
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            fault_count++;
        end
    endtask

    // drive the byte stream and the result back-pressure on the falling edge
    always @(negedge clk)
    begin : drive_items
        link_item_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_fire)
        begin
            if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = rx_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tuser  <= {nxt.start, nxt.req};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // sample all handshakes on the rising edge
    always @(posedge clk)
    begin : watch_ports
        res_t       want;
        link_item_t got_item;
        if (!rst_n)
            s_fire <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: result with none due, expected nothing actual tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    fault_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("result_kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("distance_mm", want.distance_mm, m_axis_tdata[15:0]);
                    check_field("confidence", want.confidence, m_axis_tdata[31:16]);
                    check_field("crc_ok", 16'(want.crc_ok), 16'(m_axis_tdata[32]));
                    check_field("online", 16'(want.online), 16'(m_axis_tdata[33]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLAVE_ADDR:    trk_addr  = cfg_data[7:0];
                    CFG_OUT_OF_RANGE:  trk_oor   = cfg_data;
                    CFG_OFFLINE_LIMIT: trk_limit = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                got_item.req   = s_axis_tuser[0];
                got_item.start = s_axis_tuser[1];
                got_item.data  = s_axis_tdata;
                advance_parser(got_item);
                items_taken++;
            end
            s_fire <= s_axis_tvalid && s_axis_tready;
        end
    end

    task automatic queue_item(input logic req, input logic [7:0] data, input logic start);
        link_item_t it;
        it.req   = req;
        it.data  = data;
        it.start = start;
        rx_items.push_back(it);
        items_issued++;
    endtask

    // byte k of the frame sits at bits 8k+7..8k
    function automatic logic [71:0] build_frame(input logic [7:0] addr, input logic [7:0] func,
                                                input logic [15:0] dist_mm,
                                                input logic [15:0] conf,
                                                input logic bad_crc);
        logic [71:0] f;
        logic [15:0] c;
        f[7:0]   = addr;
        f[15:8]  = func;
        f[23:16] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'd4;
        f[31:24] = dist_mm[15:8];
        f[39:32] = dist_mm[7:0];
        f[47:40] = conf[15:8];
        f[55:48] = conf[7:0];
        c = CRC_INIT;
        for (int k = 0; k < 7; k++)
            c = crc16_step(c, f[8*k +: 8]);
        f[71:56] = c;
        if (bad_crc)
            f[8*$urandom_range(1, 8) + $urandom_range(7)] ^= 1'b1;
        return f;
    endfunction

    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                               input logic [15:0] dist_mm, input logic [15:0] conf,
                               input logic bad_crc, input logic start, input int keep,
                               input int tick_pct);
        logic [71:0] f;
        f = build_frame(addr, func, dist_mm, conf, bad_crc);
        for (int k = 0; k < keep; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                queue_item(REQ_TICK, 8'($urandom), 1'($urandom));
            queue_item(REQ_BYTE, f[8*k +: 8], (k == 0) ? start : 1'b0);
        end
    endtask

    task automatic queue_ticks(input int n);
        repeat (n)
            queue_item(REQ_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLAVE_ADDR)
            st_addr = value[7:0];
        else if (idx == CFG_OFFLINE_LIMIT)
            st_limit = value[7:0];
    endtask

    // wait until every item is in and every result is out, then let the pipe empty
    task automatic settle();
        while (items_taken != items_issued || due_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int          stop_at;
        int          pick;
        logic [15:0] conf;
        logic [7:0]  func;
        logic        start;
        stop_at = items_issued + n_items;
        while (items_issued < stop_at)
        begin
            pick  = $urandom_range(99);
            conf  = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
            start = ($urandom_range(19) == 0) ? 1'b0 : 1'b1;
            func  = 8'($urandom);
            if (func == FUNC_READ)
                func = func ^ 8'h80;
            if (pick < 50)
                queue_frame(st_addr, FUNC_READ, 16'($urandom), conf, 1'b0, start, 9, 6);
            else if (pick < 60)
                queue_frame(st_addr, FUNC_READ, 16'($urandom), conf, 1'b1, start, 9, 6);
            else if (pick < 67)
                queue_frame(st_addr ^ 8'($urandom_range(1, 255)), FUNC_READ,
                            16'($urandom), conf, 1'($urandom_range(1)), start, 9, 6);
            else if (pick < 74)
                queue_frame(st_addr, func, 16'($urandom), conf, 1'b0, start, 9, 6);
            else if (pick < 80)
                queue_frame(st_addr, FUNC_READ, 16'($urandom), conf, 1'b0, start,
                            $urandom_range(1, 8), 6);
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 5))
                    queue_item(REQ_BYTE, 8'($urandom), 1'b0);
            end
            else
                queue_ticks($urandom_range(1, 4));
            // trailing bytes after a full frame are dropped by the receiver
            if (pick < 74 && $urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    queue_item(REQ_BYTE, 8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic run_phase(input int n_items, input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        sink_stall_pct = stall_pct;
        run_random(n_items);
        // long silence to push the watchdog past its limit
        queue_ticks(st_limit + 2);
        settle();
    endtask

    initial
    begin : stimulus
        logic [71:0] f;
        reset_tracker();
        st_addr  = SLAVE_ADDR_RST;
        st_limit = OFFLINE_LIMIT_RST;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // watchdog starts saturated, so the first tick reports offline
        queue_ticks(1);
        // first frame after reset needs no frame start
        queue_frame(SLAVE_ADDR_RST, FUNC_READ, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 9, 0);
        queue_item(REQ_BYTE, 8'hFF, 1'b0);
        queue_frame(SLAVE_ADDR_RST, FUNC_READ, 16'h0000, 16'h0000, 1'b0, 1'b1, 3, 0);
        // zero confidence, with a tick carrying a frame start in mid frame
        f = build_frame(SLAVE_ADDR_RST, FUNC_READ, 16'h0000, 16'h0000, 1'b0);
        for (int k = 0; k < 9; k++)
        begin
            if (k == 4)
                queue_item(REQ_TICK, 8'hA5, 1'b1);
            queue_item(REQ_BYTE, f[8*k +: 8], (k == 0) ? 1'b1 : 1'b0);
        end
        queue_ticks(1);
        run_phase(170, 0, 0);

        write_reg(CFG_SLAVE_ADDR, 16'h0000);
        write_reg(CFG_OUT_OF_RANGE, 16'h0000);
        write_reg(CFG_OFFLINE_LIMIT, 16'd1);
        run_phase(170, 70, 0);

        write_reg(CFG_SLAVE_ADDR, 16'h00FF);
        write_reg(CFG_OUT_OF_RANGE, 16'hFFFF);
        write_reg(CFG_OFFLINE_LIMIT, 16'd254);
        run_phase(170, 0, 70);

        write_reg(CFG_SPARE, 16'($urandom));
        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(255)));
        write_reg(CFG_OUT_OF_RANGE, 16'($urandom));
        write_reg(CFG_OFFLINE_LIMIT, 16'($urandom_range(1, 254)));
        run_phase(170, 25, 25);

        write_reg(CFG_SLAVE_ADDR, 16'($urandom_range(255)));
        write_reg(CFG_OUT_OF_RANGE, 16'($urandom));
        write_reg(CFG_OFFLINE_LIMIT, 16'($urandom_range(2, 20)));
        run_phase(170, 0, 0);

        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog_timer
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
sv/rmr_pkg.sv
sv/rmr_front.sv
sv/rmr_cmd_fifo.sv
sv/rmr_back.sv
sv/rangefinder_modbus_reply_receiver_unit.sv
sv/rmr_checker.sv
tb/sv/tb_rangefinder_modbus_reply_receiver_unit.sv
